// File: rtl/srcc_pkg.sv
// srcc_pkg: command codes, microcode word layout and the microcode program
// for the stack run containment counter. No dependencies.
package srcc_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int WORD_BITS_DEF   = 32;
    localparam int VALUE_W         = 32;
    localparam int CNT_W           = 7;
    localparam int UPC_W           = 4;

    typedef enum logic [1:0] {
        CMD_PUSH_A = 2'd0,
        CMD_PUSH_B = 2'd1,
        CMD_EVAL   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // Jump conditions: jump to target when true, else step to the next address.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_EVAL_START,
        C_ANY_EMPTY,
        C_NO_FIT,
        C_MISMATCH,
        C_NOT_LAST_K,
        C_PASS_FIRST,
        C_OUT_FREE
    } ucond_t;

    typedef struct packed {
        logic init;      // clear counts, first pass, first position
        logic clr_k;     // restart the pattern index
        logic rd;        // issue reads of both stacks
        logic inc_k;     // advance the pattern index
        logic inc_cnt;   // count a full match for the current pass
        logic inc_i;     // advance the start position
        logic end_pass;  // swap roles, restart the start position
        logic load_out;  // move the evaluation result to the output register
    } uops_t;

    typedef struct packed {
        uops_t            ops;
        ucond_t           cond;
        logic [UPC_W-1:0] target;
    } uword_t;

    localparam logic [UPC_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [UPC_W-1:0] ST_CHK      = 4'd1;
    localparam logic [UPC_W-1:0] ST_OUTER    = 4'd2;
    localparam logic [UPC_W-1:0] ST_RD       = 4'd3;
    localparam logic [UPC_W-1:0] ST_CMP      = 4'd4;
    localparam logic [UPC_W-1:0] ST_MORE     = 4'd5;
    localparam logic [UPC_W-1:0] ST_HIT      = 4'd6;
    localparam logic [UPC_W-1:0] ST_NEXT_I   = 4'd7;
    localparam logic [UPC_W-1:0] ST_PASS_END = 4'd8;
    localparam logic [UPC_W-1:0] ST_FINISH   = 4'd9;
    localparam logic [UPC_W-1:0] ST_WAIT     = 4'd10;

    localparam uops_t OPS_NONE = '0;

    function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
        uword_t w;
        w.ops    = OPS_NONE;
        w.cond   = C_NEVER;
        w.target = ST_IDLE;
        case (addr)
            ST_IDLE: begin
                w.ops.init = 1'b1;
                w.cond     = C_NOT_EVAL_START;
                w.target   = ST_IDLE;
            end
            ST_CHK: begin
                w.cond   = C_ANY_EMPTY;
                w.target = ST_FINISH;
            end
            ST_OUTER: begin
                w.ops.clr_k = 1'b1;
                w.cond      = C_NO_FIT;
                w.target    = ST_PASS_END;
            end
            ST_RD: begin
                w.ops.rd = 1'b1;
            end
            ST_CMP: begin
                w.cond   = C_MISMATCH;
                w.target = ST_NEXT_I;
            end
            ST_MORE: begin
                w.ops.inc_k = 1'b1;
                w.cond      = C_NOT_LAST_K;
                w.target    = ST_RD;
            end
            ST_HIT: begin
                w.ops.inc_cnt = 1'b1;
            end
            ST_NEXT_I: begin
                w.ops.inc_i = 1'b1;
                w.cond      = C_ALWAYS;
                w.target    = ST_OUTER;
            end
            ST_PASS_END: begin
                w.ops.end_pass = 1'b1;
                w.cond         = C_PASS_FIRST;
                w.target       = ST_OUTER;
            end
            ST_FINISH: begin
                w.ops.load_out = 1'b1;
                w.cond         = C_OUT_FREE;
                w.target       = ST_IDLE;
            end
            ST_WAIT: begin
                w.cond   = C_ALWAYS;
                w.target = ST_FINISH;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: rtl/srcc_ram.sv
// srcc_ram: generic single-clock RAM, one write port, one registered read port.
// No dependencies.
module srcc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/stack_run_containment_counter_core.sv
// stack_run_containment_counter_core: top level, two word stacks in srcc_ram
// and a microcoded evaluation sequencer. Depends on srcc_pkg and srcc_ram.
//
// Keeps two stacks A and B of STACK_DEPTH words each. A beat on the s_ channel
// pushes s_value onto A (command 0) or B (command 1), or evaluates (command 2):
// the result beat then gives how many start positions of A, counted from its
// top, begin a run equal to all of B from its top, the same count with A and B
// swapped (both modulo 128), and whether both stacks were non-empty. A push on
// a full stack is dropped and flagged; command 3 yields an all-zero result.
// Every input beat yields exactly one m_ beat. Pushes are accepted back to
// back while the output register can drain. An evaluation is run by a
// microcode program over one read port per stack: each matching element is
// read, checked and then the pattern index advanced, a mismatching one only
// read and checked, and each start position is entered and advanced, with a
// full hit also counted. A pass tries every start position at which the
// pattern fits in the hay, none when the pattern height exceeds the hay
// height. An evaluation runs the empty check, both passes and the finish
// after its beat; with an empty stack it runs only the check and finish.
// No new beat is taken until the evaluation result is in the output register.
module stack_run_containment_counter_core #(
    parameter int STACK_DEPTH = srcc_pkg::STACK_DEPTH_DEF,
    parameter int WORD_BITS   = srcc_pkg::WORD_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_command,
    input  logic signed [srcc_pkg::VALUE_W-1:0] s_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_push_dropped,
    output logic [srcc_pkg::CNT_W-1:0]          m_count_b_in_a,
    output logic [srcc_pkg::CNT_W-1:0]          m_count_a_in_b,
    output logic                               m_both_present
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int H_W    = $clog2(STACK_DEPTH + 1);
    localparam logic [H_W-1:0] H_ONE  = H_W'(1);
    localparam logic [H_W-1:0] H_FULL = H_W'(STACK_DEPTH);
    localparam logic [srcc_pkg::CNT_W-1:0] CNT_ONE = {{(srcc_pkg::CNT_W-1){1'b0}}, 1'b1};

    // Sequencer
    logic [srcc_pkg::UPC_W-1:0] upc_reg, upc_next;
    srcc_pkg::uword_t           uword;
    logic                       jump;

    // Stack heights and evaluation datapath
    logic [H_W-1:0]            ha_reg, ha_next, hb_reg, hb_next;
    logic [H_W-1:0]            i_reg, i_next, k_reg, k_next;
    logic                      pass_reg, pass_next;
    logic [srcc_pkg::CNT_W-1:0] cnt_ba_reg, cnt_ba_next;   // B in A
    logic [srcc_pkg::CNT_W-1:0] cnt_ab_reg, cnt_ab_next;   // A in B

    // Output register
    logic                      m_valid_reg, m_valid_next;
    logic                      drop_reg, drop_next;
    logic [srcc_pkg::CNT_W-1:0] out_ba_reg, out_ba_next;
    logic [srcc_pkg::CNT_W-1:0] out_ab_reg, out_ab_next;
    logic                      both_reg, both_next;

    logic             accept, out_free, any_empty, a_full, b_full;
    srcc_pkg::cmd_t   cmd;
    logic [WORD_BITS-1:0] word;
    logic [H_W-1:0]   hay_h, pat_h, hay_pos, pat_pos;
    logic [ADDR_W-1:0] a_raddr, b_raddr;
    logic             a_we, b_we;
    logic [WORD_BITS-1:0] a_rdata, b_rdata;

    assign cmd       = srcc_pkg::cmd_t'(s_command);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (upc_reg == srcc_pkg::ST_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign any_empty = (ha_reg == '0) || (hb_reg == '0);
    assign a_full    = (ha_reg == H_FULL);
    assign b_full    = (hb_reg == H_FULL);

    // Fit the 32-bit signed value to the stored word width.
    generate
        if (WORD_BITS <= srcc_pkg::VALUE_W) begin : g_trunc
            assign word = s_value[WORD_BITS-1:0];
        end else begin : g_sext
            assign word = {{(WORD_BITS - srcc_pkg::VALUE_W){s_value[srcc_pkg::VALUE_W-1]}},
                           s_value};
        end
    endgenerate

    // Pass 0 searches B in A (A is the hay), pass 1 searches A in B.
    assign hay_h   = pass_reg ? hb_reg : ha_reg;
    assign pat_h   = pass_reg ? ha_reg : hb_reg;
    assign hay_pos = hay_h - H_ONE - i_reg - k_reg;
    assign pat_pos = pat_h - H_ONE - k_reg;
    assign a_raddr = pass_reg ? pat_pos[ADDR_W-1:0] : hay_pos[ADDR_W-1:0];
    assign b_raddr = pass_reg ? hay_pos[ADDR_W-1:0] : pat_pos[ADDR_W-1:0];

    assign a_we = accept && (cmd == srcc_pkg::CMD_PUSH_A) && !a_full;
    assign b_we = accept && (cmd == srcc_pkg::CMD_PUSH_B) && !b_full;

    srcc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_stack_a (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (ha_reg[ADDR_W-1:0]),
        .wdata (word),
        .re    (uword.ops.rd),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    srcc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_stack_b (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (hb_reg[ADDR_W-1:0]),
        .wdata (word),
        .re    (uword.ops.rd),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // Fetch the control word and resolve the jump.
    always_comb begin
        uword = srcc_pkg::ucode_rom(upc_reg);
        case (uword.cond)
            srcc_pkg::C_NEVER:          jump = 1'b0;
            srcc_pkg::C_ALWAYS:         jump = 1'b1;
            srcc_pkg::C_NOT_EVAL_START: jump = !(accept && (cmd == srcc_pkg::CMD_EVAL));
            srcc_pkg::C_ANY_EMPTY:      jump = any_empty;
            srcc_pkg::C_NO_FIT:
                jump = ({1'b0, i_reg} + {1'b0, pat_h}) > {1'b0, hay_h};
            srcc_pkg::C_MISMATCH:       jump = (a_rdata != b_rdata);
            srcc_pkg::C_NOT_LAST_K:     jump = ((k_reg + H_ONE) != pat_h);
            srcc_pkg::C_PASS_FIRST:     jump = !pass_reg;
            srcc_pkg::C_OUT_FREE:       jump = out_free;
            default:                    jump = 1'b1;
        endcase
        upc_next = jump ? uword.target : (upc_reg + 1'b1);
    end

    // Datapath under the control word.
    always_comb begin
        ha_next     = ha_reg;
        hb_next     = hb_reg;
        i_next      = i_reg;
        k_next      = k_reg;
        pass_next   = pass_reg;
        cnt_ba_next = cnt_ba_reg;
        cnt_ab_next = cnt_ab_reg;

        if (a_we) begin
            ha_next = ha_reg + H_ONE;
        end
        if (b_we) begin
            hb_next = hb_reg + H_ONE;
        end
        if (uword.ops.init) begin
            i_next      = '0;
            pass_next   = 1'b0;
            cnt_ba_next = '0;
            cnt_ab_next = '0;
        end
        if (uword.ops.clr_k) begin
            k_next = '0;
        end
        if (uword.ops.inc_k) begin
            k_next = k_reg + H_ONE;
        end
        if (uword.ops.inc_i) begin
            i_next = i_reg + H_ONE;
        end
        if (uword.ops.inc_cnt) begin
            if (pass_reg) begin
                cnt_ab_next = cnt_ab_reg + CNT_ONE;
            end else begin
                cnt_ba_next = cnt_ba_reg + CNT_ONE;
            end
        end
        if (uword.ops.end_pass) begin
            pass_next = !pass_reg;
            i_next    = '0;
        end
    end

    // Output register: push and command 3 results load at accept, evaluation at finish.
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        drop_next    = drop_reg;
        out_ba_next  = out_ba_reg;
        out_ab_next  = out_ab_reg;
        both_next    = both_reg;
        if (accept && (cmd != srcc_pkg::CMD_EVAL)) begin
            m_valid_next = 1'b1;
            drop_next    = ((cmd == srcc_pkg::CMD_PUSH_A) && a_full) ||
                           ((cmd == srcc_pkg::CMD_PUSH_B) && b_full);
            out_ba_next  = '0;
            out_ab_next  = '0;
            both_next    = 1'b0;
        end else if (uword.ops.load_out && out_free) begin
            m_valid_next = 1'b1;
            drop_next    = 1'b0;
            out_ba_next  = cnt_ba_reg;
            out_ab_next  = cnt_ab_reg;
            both_next    = !any_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg     <= srcc_pkg::ST_IDLE;
            ha_reg      <= '0;
            hb_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            upc_reg     <= upc_next;
            ha_reg      <= ha_next;
            hb_reg      <= hb_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold payload and loop state without reset.
    always_ff @(posedge aclk) begin
        i_reg      <= i_next;
        k_reg      <= k_next;
        pass_reg   <= pass_next;
        cnt_ba_reg <= cnt_ba_next;
        cnt_ab_reg <= cnt_ab_next;
        drop_reg   <= drop_next;
        out_ba_reg <= out_ba_next;
        out_ab_reg <= out_ab_next;
        both_reg   <= both_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_push_dropped = drop_reg;
    assign m_count_b_in_a = out_ba_reg;
    assign m_count_a_in_b = out_ab_reg;
    assign m_both_present = both_reg;

    // Heights never pass the stack depth.
    a_height_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (ha_reg <= H_FULL) && (hb_reg <= H_FULL))
        else $error("stack height beyond depth");

    // A push onto a full A stack comes back flagged as dropped.
    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (cmd == srcc_pkg::CMD_PUSH_A) && a_full) |=> (m_valid && m_push_dropped))
        else $error("full-stack push not flagged");

    // Stacks hold still while an evaluation runs.
    a_eval_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (upc_reg != srcc_pkg::ST_IDLE) |=> ((ha_reg == $past(ha_reg)) &&
                                           (hb_reg == $past(hb_reg))))
        else $error("stack height changed during evaluation");

endmodule
